FILE: rtl/wbpm_pkg.sv
// Shared types and constants for the write block pool manager.
// No dependencies; imported by every module of the block.
package wbpm_pkg;

  localparam int POOL_BLOCKS = 32;
  localparam int IDX_W       = $clog2(POOL_BLOCKS);
  localparam int CNT_W       = $clog2(POOL_BLOCKS + 1);
  localparam int FILL_W      = 21;
  localparam int OFF_W       = 48;
  localparam int TGT_W       = 27;
  localparam int DATA_W      = 80;

  // operation codes
  localparam logic [2:0] OP_ACQUIRE = 3'd0;
  localparam logic [2:0] OP_READY   = 3'd1;
  localparam logic [2:0] OP_FLUSH   = 3'd2;
  localparam logic [2:0] OP_DEQUEUE = 3'd3;
  localparam logic [2:0] OP_RELEASE = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFREE  = 3'd1;
  localparam logic [2:0] ST_TOOBIG  = 3'd2;
  localparam logic [2:0] ST_BADIDX  = 3'd3;
  localparam logic [2:0] ST_WAIT    = 3'd4;
  localparam logic [2:0] ST_DRAINED = 3'd5;

  // per-block state
  typedef enum logic [2:0] {
    BLK_FREE    = 3'd0,
    BLK_FILLING = 3'd1,
    BLK_READY   = 3'd2,
    BLK_PENDING = 3'd3,
    BLK_WRITING = 3'd4
  } blk_state_t;

  // sequencer state
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_DECODE,
    SEQ_ACQ,
    SEQ_FLUSH,
    SEQ_DQ_COUNT,
    SEQ_DQ_WAKE,
    SEQ_DQ_EMIT,
    SEQ_RESP
  } seq_state_t;

  // configuration register indexes
  localparam logic [1:0] CFG_BLOCK_BYTES = 2'd0;
  localparam logic [1:0] CFG_TARGET      = 2'd1;
  localparam logic [1:0] CFG_WRITERS_RUN = 2'd2;

endpackage

FILE: rtl/wbpm_accum.sv
// Shared accumulate-and-compare unit: running byte sum against the target.
// Depends on wbpm_pkg.
module wbpm_accum (
  input  logic                       clk,
  input  logic                       clear,
  input  logic                       add_en,
  input  logic [wbpm_pkg::FILL_W-1:0] addend,
  input  logic [wbpm_pkg::TGT_W-1:0]  target,
  output logic                       hit
);
  import wbpm_pkg::*;

  logic [TGT_W-1:0] sum;
  logic [TGT_W-1:0] sum_next;

  // one add and one compare per scan step
  always_comb begin
    sum_next = sum + (add_en ? TGT_W'(addend) : '0);
    hit      = (sum_next >= target);
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      sum <= '0;
    end else begin
      sum <= sum_next;
    end
  end
endmodule

FILE: rtl/write_block_pool_manager.sv
// Top level of the write block pool manager: sequencer, block table, result register.
// Depends on wbpm_pkg and wbpm_accum.
//
// One operation is taken at a time; s_tready is low while it is worked on. Release
// and mark ready go from decode straight to the result. Acquire and flush walk the
// 32 block entries one per cycle, acquire until a free block is found and flush until
// the shared sum/compare unit reaches the target. A dequeue walks the table twice,
// once to size the batch and once to hand it out; the hand-out walk stalls while the
// output side is not ready. Results leave through a one-entry output register.
module write_block_pool_manager (
  input  logic                        clk,
  input  logic                        rst,
  // config write port
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [wbpm_pkg::TGT_W-1:0]  cfg_data,
  // operation stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // operation, block_index, file_offset, byte_count, flush_partial
  input  logic [wbpm_pkg::DATA_W-1:0] s_tdata,
  // result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // status, granted_index, block_offset, block_length, wake_writers
  output logic [wbpm_pkg::DATA_W-1:0] m_tdata,
  output logic                        m_tlast
);
  import wbpm_pkg::*;

  // configuration
  logic [FILL_W-1:0] block_bytes;
  logic [TGT_W-1:0]  target;
  logic              writers_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= FILL_W'(65536);
      target      <= TGT_W'(1048576);
      writers_run <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_BYTES: block_bytes <= cfg_data[FILL_W-1:0];
        CFG_TARGET:      target      <= cfg_data;
        CFG_WRITERS_RUN: writers_run <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // latched operation
  logic [2:0]        op;
  logic [IDX_W-1:0]  op_idx;
  logic [OFF_W-1:0]  op_off;
  logic [FILL_W-1:0] op_cnt;
  logic              op_partial;

  // block table
  blk_state_t        blk_state [POOL_BLOCKS];
  logic [FILL_W-1:0] blk_fill  [POOL_BLOCKS];
  logic [OFF_W-1:0]  blk_pos   [POOL_BLOCKS];
  logic [CNT_W-1:0]  ready_cnt, pend_cnt;

  // sequencer registers
  seq_state_t        seq, seq_next;
  logic [IDX_W-1:0]  scan, scan_next;
  logic [CNT_W-1:0]  n_blk, n_blk_next;
  logic [CNT_W-1:0]  n_out, n_out_next;
  logic              wake, wake_next;
  logic [2:0]        res_status, res_status_next;
  logic [IDX_W-1:0]  res_idx, res_idx_next;

  // table write controls
  logic              st_we;
  logic [IDX_W-1:0]  st_widx;
  blk_state_t        st_wval;
  logic              data_we;

  // output register load
  logic              can_put;
  logic              put;
  logic [DATA_W-1:0] put_data;
  logic              put_last;

  // shared unit controls
  logic              acc_clear, acc_add, acc_hit;
  logic [CNT_W-1:0]  mul_cnt;
  logic [TGT_W-1:0]  mul_bytes;

  blk_state_t        cur_state;
  logic              last_scan;

  assign cur_state = blk_state[scan];
  assign last_scan = (scan == IDX_W'(POOL_BLOCKS - 1));
  assign can_put   = !m_tvalid || m_tready;
  assign s_tready  = (seq == SEQ_IDLE);

  wbpm_accum u_accum (
    .clk    (clk),
    .clear  (acc_clear),
    .add_en (acc_add),
    .addend (blk_fill[scan]),
    .target (target),
    .hit    (acc_hit)
  );

  // block count times block size
  assign mul_bytes = TGT_W'(mul_cnt) * TGT_W'(block_bytes);

  // next state
  always_comb begin
    seq_next = seq;
    unique case (seq)
      SEQ_IDLE:   if (s_tvalid) seq_next = SEQ_DECODE;
      SEQ_DECODE: begin
        unique case (op)
          OP_ACQUIRE: seq_next = (op_cnt > block_bytes) ? SEQ_RESP : SEQ_ACQ;
          OP_FLUSH: begin
            if (mul_bytes >= target || (ready_cnt != '0 && block_bytes != '0 && op_partial))
              seq_next = SEQ_FLUSH;
            else
              seq_next = SEQ_RESP;
          end
          OP_DEQUEUE: begin
            if (!writers_run && mul_bytes == '0)
              seq_next = SEQ_RESP;
            else if (writers_run && mul_bytes < target)
              seq_next = SEQ_RESP;
            else
              seq_next = SEQ_DQ_COUNT;
          end
          default: seq_next = SEQ_RESP;
        endcase
      end
      SEQ_ACQ:   if (cur_state == BLK_FREE || last_scan) seq_next = SEQ_RESP;
      SEQ_FLUSH: if (acc_hit || last_scan) seq_next = SEQ_RESP;
      SEQ_DQ_COUNT: begin
        if (acc_hit || last_scan)
          seq_next = (n_blk_next == '0) ? SEQ_RESP : SEQ_DQ_WAKE;
      end
      SEQ_DQ_WAKE: seq_next = SEQ_DQ_EMIT;
      SEQ_DQ_EMIT: begin
        if (cur_state == BLK_PENDING && can_put && n_out + 1'b1 == n_blk)
          seq_next = SEQ_IDLE;
      end
      SEQ_RESP: if (can_put) seq_next = SEQ_IDLE;
      default:  seq_next = SEQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    scan_next       = scan;
    n_blk_next      = n_blk;
    n_out_next      = n_out;
    wake_next       = wake;
    res_status_next = res_status;
    res_idx_next    = res_idx;
    st_we           = 1'b0;
    st_widx         = scan;
    st_wval         = BLK_FREE;
    data_we         = 1'b0;
    acc_clear       = 1'b0;
    acc_add         = 1'b0;
    mul_cnt         = ready_cnt;
    put             = 1'b0;
    put_last        = 1'b1;
    put_data        = '0;
    unique case (seq)
      SEQ_IDLE: ;
      SEQ_DECODE: begin
        scan_next       = '0;
        n_blk_next      = '0;
        n_out_next      = '0;
        wake_next       = 1'b0;
        res_status_next = ST_OK;
        res_idx_next    = '0;
        acc_clear       = 1'b1;
        mul_cnt         = (op == OP_DEQUEUE) ? pend_cnt : ready_cnt;
        unique case (op)
          OP_ACQUIRE: if (op_cnt > block_bytes) res_status_next = ST_TOOBIG;
          OP_READY: begin
            st_we   = 1'b1;
            st_widx = op_idx;
            st_wval = BLK_READY;
            data_we = 1'b1;
          end
          OP_RELEASE: begin
            st_we   = 1'b1;
            st_widx = op_idx;
            st_wval = BLK_FREE;
          end
          OP_DEQUEUE: begin
            if (!writers_run && mul_bytes == '0)
              res_status_next = ST_DRAINED;
            else if (writers_run && mul_bytes < target)
              res_status_next = ST_WAIT;
          end
          default: ;
        endcase
      end
      SEQ_ACQ: begin
        if (cur_state == BLK_FREE) begin
          st_we        = 1'b1;
          st_wval      = BLK_FILLING;
          res_idx_next = scan;
        end else if (last_scan) begin
          res_status_next = ST_NOFREE;
        end
        scan_next = scan + 1'b1;
      end
      SEQ_FLUSH: begin
        acc_add = (cur_state == BLK_READY);
        if (cur_state == BLK_READY) begin
          st_we     = 1'b1;
          st_wval   = BLK_PENDING;
          wake_next = 1'b1;
        end
        scan_next = scan + 1'b1;
      end
      SEQ_DQ_COUNT: begin
        acc_add = (cur_state == BLK_PENDING);
        if (cur_state == BLK_PENDING) n_blk_next = n_blk + 1'b1;
        if ((acc_hit || last_scan) && n_blk_next == '0) res_status_next = ST_WAIT;
        scan_next = scan + 1'b1;
      end
      SEQ_DQ_WAKE: begin
        // pending blocks that stay behind after this batch
        mul_cnt   = pend_cnt - n_blk;
        wake_next = (mul_bytes >= target);
        scan_next = '0;
      end
      SEQ_DQ_EMIT: begin
        if (cur_state == BLK_PENDING) begin
          if (can_put) begin
            put        = 1'b1;
            put_last   = (n_out + 1'b1 == n_blk);
            put_data   = {2'b00, wake, blk_fill[scan], blk_pos[scan], scan, ST_OK};
            st_we      = 1'b1;
            st_wval    = BLK_WRITING;
            n_out_next = n_out + 1'b1;
            scan_next  = scan + 1'b1;
          end
        end else begin
          scan_next = scan + 1'b1;
        end
      end
      SEQ_RESP: begin
        put      = can_put;
        put_data = {2'b00, wake, FILL_W'(0), OFF_W'(0), res_idx, res_status};
      end
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SEQ_IDLE;
    end else begin
      seq <= seq_next;
    end
    scan       <= scan_next;
    n_blk      <= n_blk_next;
    n_out      <= n_out_next;
    wake       <= wake_next;
    res_status <= res_status_next;
    res_idx    <= res_idx_next;
  end

  // operation capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op         <= s_tdata[2:0];
      op_idx     <= s_tdata[7:3];
      op_off     <= s_tdata[55:8];
      op_cnt     <= s_tdata[76:56];
      op_partial <= s_tdata[77];
    end
  end

  // block state table with ready and pending counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < POOL_BLOCKS; i++) blk_state[i] <= BLK_FREE;
      ready_cnt <= '0;
      pend_cnt  <= '0;
    end else if (st_we) begin
      blk_state[st_widx] <= st_wval;
      ready_cnt <= ready_cnt - CNT_W'(blk_state[st_widx] == BLK_READY)
                             + CNT_W'(st_wval == BLK_READY);
      pend_cnt  <= pend_cnt - CNT_W'(blk_state[st_widx] == BLK_PENDING)
                            + CNT_W'(st_wval == BLK_PENDING);
    end
  end

  // block fill and position
  always_ff @(posedge clk) begin
    if (data_we) begin
      blk_fill[op_idx] <= op_cnt;
      blk_pos[op_idx]  <= op_off;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (put) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (put) begin
      m_tdata <= put_data;
      m_tlast <= put_last;
    end
  end
endmodule
